### src/ofc_pkg.sv
// Package for the overlap-add convolver: sizes, opcodes and the command type.
// Used by ofc_front, ofc_back and the top module; depends on nothing.
package ofc_pkg;

    localparam int FRAME_LEN  = 512;
    localparam int FFT_POINTS = 1024;
    localparam int TAPS       = FFT_POINTS / 2 + 1;
    localparam int POS_W      = $clog2(FRAME_LEN);
    localparam int TAP_AW     = $clog2(TAPS);
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 18;
    localparam int IDX_W      = 10;
    // Partial sums: 34-bit products summed over up to one frame.
    localparam int ACC_W      = SAMPLE_W + COEF_W + POS_W + 2;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    typedef struct packed {
        logic                       is_load;
        logic signed [SAMPLE_W-1:0] sample;
        logic [IDX_W-1:0]           idx;
        logic signed [COEF_W-1:0]   value;
    } t_cmd;

    // Round at 2^-16 and saturate to Q1.15.
    function automatic logic signed [SAMPLE_W-1:0] round_sat(
        input logic signed [ACC_W:0] v
    );
        logic signed [ACC_W+1:0] a;
        logic signed [ACC_W+1:0] q;
        a = {v[ACC_W], v} + (ACC_W+2)'(32768);
        q = a >>> 16;
        if (q > (ACC_W+2)'(32767)) begin
            return SAMPLE_W'(32767);
        end else if (q < -(ACC_W+2)'(32768)) begin
            return SAMPLE_W'(-32768);
        end
        return q[SAMPLE_W-1:0];
    endfunction

endpackage

### src/ofc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ofc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### src/ofc_front.sv
// Front end: accepts requests, drops out-of-range tap loads, and queues
// commands for the back end. Depends on ofc_pkg.
module ofc_front import ofc_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       i_opcode,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    input  logic [IDX_W-1:0]           i_coef_index,
    input  logic signed [COEF_W-1:0]   i_coef_value,
    output logic                       o_cmd_valid,
    output t_cmd                       o_cmd,
    input  logic                       i_cmd_pop
);
    t_cmd r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;
    logic       w_acc;
    logic       w_keep;
    logic       w_pop;
    t_cmd       w_cmd;

    assign full        = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];
    assign w_acc       = push && !full;
    assign w_keep      = w_acc && !(i_opcode == OP_LOAD && i_coef_index >= IDX_W'(TAPS));
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    always_comb begin
        w_cmd.is_load = (i_opcode == OP_LOAD);
        w_cmd.sample  = i_sample_in;
        w_cmd.idx     = i_coef_index;
        w_cmd.value   = i_coef_value;
    end

    always_ff @(posedge i_clk) begin
        if (w_keep) begin
            r_q[r_wr] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (w_keep) begin
                r_wr <= !r_wr;
            end
            if (w_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(w_keep) - 2'(w_pop);
        end
    end
endmodule

### src/ofc_back.sv
// Back end: tap store, frame memories, direct-form frame convolution with
// one multiply-accumulate per cycle, and the result queue. Depends on ofc_pkg, ofc_ram.
module ofc_back import ofc_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_pass_through,
    input  logic                       i_cmd_valid,
    input  t_cmd                       i_cmd,
    output logic                       o_cmd_pop,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [SAMPLE_W-1:0] o_sample_out
);
    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_PT   = 3'd3;
    localparam logic [2:0] S_FK   = 3'd4;
    localparam logic [2:0] S_MAC  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    localparam int CNT_W = TAP_AW + 1;

    logic [2:0]       r_state;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] r_k;
    logic [CNT_W-1:0] r_j;
    logic             r_out_zero;
    logic             r_tail_zero;
    logic             r_v1, r_v2, r_t1, r_t2;
    logic signed [SAMPLE_W+COEF_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc_lo, r_acc_tail, r_tail_val;

    logic signed [SAMPLE_W-1:0] r_rq [2];
    logic [1:0] r_rcnt;
    logic       r_rrd, r_rwr;
    logic       w_rpush;
    logic signed [SAMPLE_W-1:0] w_rdata;

    logic              w_tap_we;
    logic [TAP_AW-1:0] w_tap_wa, w_tap_ra;
    logic [COEF_W-1:0] w_tap_wd, w_tap_rd;
    logic              w_x_we;
    logic [POS_W-1:0]  w_x_ra;
    logic [SAMPLE_W-1:0] w_x_rd;
    logic              w_o_we;
    logic [POS_W-1:0]  w_o_wa;
    logic [SAMPLE_W-1:0] w_o_wd, w_o_rd;
    logic              w_t_we;
    logic [ACC_W-1:0]  w_t_rd;
    logic              w_issue;
    logic [CNT_W-1:0]  w_k_ext;
    logic signed [ACC_W:0] w_sum;

    assign empty        = (r_rcnt == 2'd0);
    assign o_sample_out = r_rq[r_rrd];
    assign w_k_ext      = CNT_W'(r_k);
    assign w_issue      = (r_state == S_MAC) && (r_j <= CNT_W'(TAPS - 1));
    assign w_sum        = {r_acc_lo[ACC_W-1], r_acc_lo} + {r_tail_val[ACC_W-1], r_tail_val};

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid && (r_rcnt != 2'd2);

    always_comb begin
        w_tap_we = 1'b0;
        w_tap_wa = r_j[TAP_AW-1:0];
        w_tap_wd = '0;
        if (r_state == S_CLR) begin
            w_tap_we = 1'b1;
        end else if (o_cmd_pop && i_cmd.is_load) begin
            w_tap_we = 1'b1;
            w_tap_wa = i_cmd.idx[TAP_AW-1:0];
            w_tap_wd = i_cmd.value;
        end
        // Low half of the point takes taps k-q; high half takes k+FRAME_LEN-q.
        if (r_j == CNT_W'(TAPS - 1)) begin
            w_tap_ra = TAP_AW'(TAPS - 1);
        end else if (r_j <= w_k_ext) begin
            w_tap_ra = TAP_AW'(w_k_ext - r_j);
        end else begin
            w_tap_ra = TAP_AW'(w_k_ext + CNT_W'(FRAME_LEN) - r_j);
        end
        if (r_state == S_PT || r_j != CNT_W'(TAPS - 1)) begin
            w_x_ra = r_j[POS_W-1:0];
        end else begin
            w_x_ra = r_k;
        end
        w_x_we = o_cmd_pop && !i_cmd.is_load;
        w_o_we = 1'b0;
        w_o_wa = r_k;
        w_o_wd = round_sat(w_sum);
        if (r_state == S_PT && r_j != '0) begin
            w_o_we = 1'b1;
            w_o_wa = POS_W'(r_j - CNT_W'(1));
            w_o_wd = w_x_rd;
        end else if (r_state == S_FIN) begin
            w_o_we = 1'b1;
        end
        w_t_we  = (r_state == S_FIN);
        w_rpush = (r_state == S_RD);
        w_rdata = r_out_zero ? '0 : w_o_rd;
    end

    ofc_ram #(.WIDTH(COEF_W), .DEPTH(TAPS)) u_tap (
        .i_clk, .i_we(w_tap_we), .i_waddr(w_tap_wa), .i_wdata(w_tap_wd),
        .i_raddr(w_tap_ra), .o_rdata(w_tap_rd)
    );
    ofc_ram #(.WIDTH(SAMPLE_W), .DEPTH(FRAME_LEN)) u_xin (
        .i_clk, .i_we(w_x_we), .i_waddr(r_pos), .i_wdata(i_cmd.sample),
        .i_raddr(w_x_ra), .o_rdata(w_x_rd)
    );
    ofc_ram #(.WIDTH(SAMPLE_W), .DEPTH(FRAME_LEN)) u_outf (
        .i_clk, .i_we(w_o_we), .i_waddr(w_o_wa), .i_wdata(w_o_wd),
        .i_raddr(r_pos), .o_rdata(w_o_rd)
    );
    ofc_ram #(.WIDTH(ACC_W), .DEPTH(FRAME_LEN)) u_tail (
        .i_clk, .i_we(w_t_we), .i_waddr(r_k), .i_wdata(r_acc_tail),
        .i_raddr(r_k), .o_rdata(w_t_rd)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(w_x_rd) * $signed(w_tap_rd);
        if (w_rpush) begin
            r_rq[r_rwr] <= w_rdata;
        end
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_pos       <= '0;
            r_k         <= '0;
            r_j         <= '0;
            r_out_zero  <= 1'b1;
            r_tail_zero <= 1'b1;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_t1        <= 1'b0;
            r_t2        <= 1'b0;
            r_rcnt      <= 2'd0;
            r_rrd       <= 1'b0;
            r_rwr       <= 1'b0;
        end else begin
            r_v1 <= w_issue;
            r_t1 <= (r_j == CNT_W'(TAPS - 1)) || (r_j > w_k_ext);
            r_v2 <= r_v1;
            r_t2 <= r_t1;
            if (r_v2) begin
                if (r_t2) begin
                    r_acc_tail <= r_acc_tail + ACC_W'(r_prod);
                end else begin
                    r_acc_lo <= r_acc_lo + ACC_W'(r_prod);
                end
            end
            if (w_rpush) begin
                r_rwr <= !r_rwr;
            end
            if (pop && !empty) begin
                r_rrd <= !r_rrd;
            end
            r_rcnt <= r_rcnt + 2'(w_rpush) - 2'(pop && !empty);

            unique case (r_state)
                S_CLR: begin
                    r_j <= r_j + CNT_W'(1);
                    if (r_j == CNT_W'(TAPS - 1)) begin
                        r_j     <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        if (i_cmd.is_load) begin
                            r_out_zero  <= 1'b1;
                            r_tail_zero <= 1'b1;
                            r_pos       <= '0;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_pos <= r_pos + POS_W'(1);
                    r_j   <= '0;
                    r_k   <= '0;
                    if (r_pos == POS_W'(FRAME_LEN - 1)) begin
                        r_state <= i_pass_through ? S_PT : S_FK;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_PT: begin
                    r_j <= r_j + CNT_W'(1);
                    if (r_j == CNT_W'(FRAME_LEN)) begin
                        r_out_zero <= 1'b0;
                        r_j        <= '0;
                        r_state    <= S_IDLE;
                    end
                end
                S_FK: begin
                    r_acc_lo   <= '0;
                    r_acc_tail <= '0;
                    r_j        <= '0;
                    r_state    <= S_MAC;
                end
                S_MAC: begin
                    if (r_j == '0) begin
                        r_tail_val <= r_tail_zero ? '0 : w_t_rd;
                    end
                    r_j <= r_j + CNT_W'(1);
                    // Move to S_FIN once the last product has passed the read and product registers into the sum.
                    if (r_j == CNT_W'(TAPS + 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_k <= r_k + POS_W'(1);
                    r_j <= '0;
                    if (r_k == POS_W'(FRAME_LEN - 1)) begin
                        r_out_zero  <= 1'b0;
                        r_tail_zero <= 1'b0;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_FK;
                    end
                end
                default: begin
                    r_state <= S_CLR;
                end
            endcase
        end
    end

    a_rq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcnt != 2'd3) else $error("result queue overflow");
    a_no_cmd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> r_state == S_IDLE) else $error("command taken while busy");
    a_push_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rpush |-> r_rcnt != 2'd2 || (pop && !empty)) else $error("result lost");
endmodule

### src/overlap_add_fft_convolver.sv
// Overlap-add convolver, 513 taps over 512-sample frames. Each audio sample
// request returns one output sample, the filtered input delayed by one frame
// (in pass-through, the input itself). After reset the tap store is cleared
// before the first request is served. A sample is taken in the back end's
// S_IDLE state and its result is queued in S_RD; the last sample of a frame
// then runs the frame convolution on one multiply-accumulate unit, point by
// point over 512 points, or a frame copy in pass-through; a tap load is taken
// in S_IDLE, which it does not leave. Depends on ofc_pkg, ofc_front, ofc_back.
module overlap_add_fft_convolver import ofc_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_wdata,
    input  logic                       push,
    output logic                       full,
    input  logic                       i_opcode,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    input  logic [IDX_W-1:0]           i_coef_index,
    input  logic signed [COEF_W-1:0]   i_coef_value,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [SAMPLE_W-1:0] o_sample_out
);
    logic r_pass_through;
    logic w_cmd_valid;
    logic w_cmd_pop;
    t_cmd w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass_through <= 1'b0;
        end else if (i_cfg_we) begin
            r_pass_through <= i_cfg_wdata;
        end
    end

    ofc_front u_front (
        .i_clk, .i_rst_n, .push, .full, .i_opcode, .i_sample_in,
        .i_coef_index, .i_coef_value,
        .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd), .i_cmd_pop(w_cmd_pop)
    );

    ofc_back u_back (
        .i_clk, .i_rst_n, .i_pass_through(r_pass_through),
        .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd), .o_cmd_pop(w_cmd_pop),
        .empty, .pop, .o_sample_out
    );
endmodule

### tb/overlap_add_fft_convolver_tb.sv
// Self-checking testbench for overlap_add_fft_convolver: directed table, then random
// pass-through and filter frames checked against a predictor. Depends on ofc_pkg.
`timescale 1ns / 1ps

module overlap_add_fft_convolver_tb;
    import ofc_pkg::*;

    localparam int WATCHDOG_LIMIT = 1200000;

    typedef struct {
        logic                       op;
        logic signed [SAMPLE_W-1:0] sample;
        logic [IDX_W-1:0]           idx;
        logic signed [COEF_W-1:0]   value;
        logic signed [SAMPLE_W-1:0] typed_out;
    } t_dir_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic                       i_cfg_wdata = 1'b0;
    logic                       push = 1'b0;
    logic                       full;
    logic                       i_opcode = OP_SAMPLE;
    logic signed [SAMPLE_W-1:0] i_sample_in = '0;
    logic [IDX_W-1:0]           i_coef_index = '0;
    logic signed [COEF_W-1:0]   i_coef_value = '0;
    logic                       empty;
    logic                       pop = 1'b0;
    logic signed [SAMPLE_W-1:0] o_sample_out;

    // Convolver model state.
    logic signed [COEF_W-1:0]   tap_mem [TAPS];
    logic signed [SAMPLE_W-1:0] frame_in [FRAME_LEN];
    logic signed [SAMPLE_W-1:0] frame_out [FRAME_LEN];
    longint                     tail_sum [FRAME_LEN];
    int                         fpos = 0;
    bit                         pt_mode = 1'b0;
    int                         busy_cycles = 20;

    logic signed [SAMPLE_W-1:0] out_expect_q [$];
    t_dir_row                   dir_rows [$];

    int  errors = 0;
    int  requests = 0;
    int  results = 0;
    int  frame_ends = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;
    bit  long_hold = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_left = 0;
    int  rx_gap = 0;
    logic signed [SAMPLE_W-1:0] want;

    overlap_add_fft_convolver dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .push         (push),
        .full         (full),
        .i_opcode     (i_opcode),
        .i_sample_in  (i_sample_in),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .empty        (empty),
        .pop          (pop),
        .o_sample_out (o_sample_out)
    );

    always #6 i_clk = ~i_clk;

    // One point of the circular convolution of the gathered frame with the taps.
    function automatic longint circ_point(int k);
        longint acc;
        int     d;
        acc = 0;
        for (int q = 0; q < FRAME_LEN; q++) begin
            d = (k - q + FFT_POINTS) % FFT_POINTS;
            if (d < TAPS) begin
                acc += longint'(frame_in[q]) * longint'(tap_mem[d]);
            end
        end
        return acc;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] to_q15(longint v);
        longint a;
        a = (v + 32768) >>> 16;
        if (a > 32767) begin
            return 16'sh7FFF;
        end else if (a < -32768) begin
            return 16'sh8000;
        end
        return a[SAMPLE_W-1:0];
    endfunction

    task automatic predict_request(
        input  logic                       op,
        input  logic signed [SAMPLE_W-1:0] s,
        input  logic [IDX_W-1:0]           idx,
        input  logic signed [COEF_W-1:0]   v,
        output bit                         gives,
        output logic signed [SAMPLE_W-1:0] y
    );
        longint lo;
        gives = 1'b0;
        y = '0;
        busy_cycles = 20;
        if (op == OP_LOAD) begin
            // Out-of-range tap numbers leave everything untouched.
            if (idx < TAPS) begin
                tap_mem[idx] = v;
                for (int i = 0; i < FRAME_LEN; i++) begin
                    tail_sum[i] = 0;
                    frame_out[i] = '0;
                end
                fpos = 0;
            end
        end else begin
            gives = 1'b1;
            y = frame_out[fpos];
            frame_in[fpos] = s;
            fpos++;
            if (fpos == FRAME_LEN) begin
                fpos = 0;
                frame_ends++;
                if (pt_mode) begin
                    busy_cycles = 700;
                    for (int i = 0; i < FRAME_LEN; i++) frame_out[i] = frame_in[i];
                end else begin
                    busy_cycles = 280000;
                    for (int i = 0; i < FRAME_LEN; i++) begin
                        lo = circ_point(i) + tail_sum[i];
                        frame_out[i] = to_q15(lo);
                        tail_sum[i] = circ_point(i + FRAME_LEN);
                    end
                end
            end
        end
    endtask

    // Offer one request, wait for it to be taken, then record what it should return.
    task automatic send_request(
        input logic                       op,
        input logic signed [SAMPLE_W-1:0] s,
        input logic [IDX_W-1:0]           idx,
        input logic signed [COEF_W-1:0]   v,
        input bit                         typed,
        input logic signed [SAMPLE_W-1:0] typed_out
    );
        bit                         gives;
        logic signed [SAMPLE_W-1:0] y;
        push         <= 1'b1;
        i_opcode     <= op;
        i_sample_in  <= s;
        i_coef_index <= idx;
        i_coef_value <= v;
        do @(posedge i_clk); while (full);
        requests++;
        predict_request(op, s, idx, v, gives, y);
        if (gives) out_expect_q.push_back(typed ? typed_out : y);
        if (!calm && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    task automatic drain_and_settle();
        while (out_expect_q.size() != 0) @(posedge i_clk);
        repeat (busy_cycles) @(posedge i_clk);
    endtask

    task automatic write_pass_through(input logic val);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        pt_mode = val;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 511) - 256);
            1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Result side: checks taken results and throttles pop.
    always @(posedge i_clk) begin : result_side
        if (i_rst_n && pop && !empty) begin
            results++;
            if (out_expect_q.size() == 0) begin
                $error("unexpected result: sample_out=%0d", o_sample_out);
                errors++;
            end else begin
                want = out_expect_q.pop_front();
                if (o_sample_out !== want) begin
                    $error("sample_out mismatch: expected %0d, got %0d", want, o_sample_out);
                    errors++;
                end
            end
        end
        if (long_hold && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            pop <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            rx_gap = $urandom_range(1, 11) - 1;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("overlap_add_fft_convolver_tb: errors");
            $finish;
        end
    end

    initial begin : stimulus
        t_dir_row r;
        for (int i = 0; i < TAPS; i++) tap_mem[i] = '0;
        for (int i = 0; i < FRAME_LEN; i++) begin
            frame_in[i] = '0;
            frame_out[i] = '0;
            tail_sum[i] = 0;
        end

        // Right after reset and right after a tap load the output frame is all zero.
        dir_rows.push_back('{OP_SAMPLE, 16'sh7FFF, 10'd0, 18'sd0, 16'sd0});
        dir_rows.push_back('{OP_SAMPLE, 16'sh8000, 10'd0, 18'sd0, 16'sd0});
        dir_rows.push_back('{OP_SAMPLE, 16'sh0000, 10'd0, 18'sd0, 16'sd0});
        dir_rows.push_back('{OP_SAMPLE, 16'sh5555, 10'd0, 18'sd0, 16'sd0});
        dir_rows.push_back('{OP_LOAD, 16'sd0, 10'd0, 18'sh1FFFF, 16'sd0});
        dir_rows.push_back('{OP_LOAD, 16'sd0, 10'd512, 18'sh20000, 16'sd0});
        dir_rows.push_back('{OP_LOAD, 16'sd0, 10'd513, 18'sd1, 16'sd0});
        dir_rows.push_back('{OP_LOAD, 16'sd0, 10'd1023, -18'sd1, 16'sd0});
        dir_rows.push_back('{OP_LOAD, 16'sd0, 10'd511, 18'sh2AAAA, 16'sd0});
        dir_rows.push_back('{OP_LOAD, 16'sd0, 10'd1, 18'sh15555, 16'sd0});
        dir_rows.push_back('{OP_SAMPLE, 16'shAAAA, 10'd0, 18'sd0, 16'sd0});
        dir_rows.push_back('{OP_SAMPLE, -16'sd1, 10'd0, 18'sd0, 16'sd0});
        dir_rows.push_back('{OP_SAMPLE, 16'sd1, 10'd0, 18'sd0, 16'sd0});
        dir_rows.push_back('{OP_SAMPLE, 16'sh7FFF, 10'd0, 18'sd0, 16'sd0});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_pass_through(1'b0);

        foreach (dir_rows[n]) begin
            r = dir_rows[n];
            send_request(r.op, r.sample, r.idx, r.value, 1'b1, r.typed_out);
        end
        push <= 1'b0;
        drain_and_settle();

        // Pass-through: a few stray loads, then enough samples to cross a frame end.
        write_pass_through(1'b1);
        repeat (6) begin
            send_request(OP_LOAD, 16'($urandom), 10'($urandom_range(0, 1023)),
                         18'($urandom), 1'b0, '0);
        end
        for (int n = 0; n < 540; n++) begin
            if (n == 100) long_hold = 1'b1;
            if (n == 300) begin
                push <= 1'b0;
                do @(posedge i_clk); while (out_expect_q.size() != 0);
            end
            send_request(OP_SAMPLE, rand_sample(), 10'($urandom), 18'($urandom), 1'b0, '0);
        end
        push <= 1'b0;
        drain_and_settle();

        // Filter mode: load taps at both ends and some in between, then run one
        // whole frame and read part of the filtered frame that follows.
        write_pass_through(1'b0);
        send_request(OP_LOAD, '0, 10'd0, 18'($urandom), 1'b0, '0);
        send_request(OP_LOAD, '0, 10'd512, 18'($urandom), 1'b0, '0);
        repeat (6) begin
            send_request(OP_LOAD, '0, 10'($urandom_range(0, 512)),
                         $urandom_range(0, 1) ? 18'($urandom) : 18'($urandom_range(0, 4095) - 2048),
                         1'b0, '0);
        end
        for (int n = 0; n < 560; n++) begin
            if (n == 460) calm = 1'b1;
            send_request(OP_SAMPLE, rand_sample(), 10'($urandom), 18'($urandom), 1'b0, '0);
        end
        push <= 1'b0;
        drain_and_settle();

        $display("Ran %0d requests, %0d results checked, %0d frame ends in both modes.",
                 requests, results, frame_ends);
        if (out_expect_q.size() != 0) begin
            $error("%0d expected results never arrived", out_expect_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("overlap_add_fft_convolver_tb: clean");
        end else begin
            $display("overlap_add_fft_convolver_tb: errors");
        end
        $finish;
    end

endmodule
